>>> src/button_click_event_detector_macros.svh
// assertion helpers for the button click event detector
`ifndef BUTTON_CLICK_EVENT_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_MACROS_SVH

// same-cycle implication, off during reset
`define BCED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define BCED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers reset itself
`define BCED_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/bced_pkg.sv
package bced_pkg;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_DOWN   = 3'd1,
    EV_UP     = 3'd2,
    EV_REPEAT = 3'd3,
    EV_SINGLE = 3'd4,
    EV_DOUBLE = 3'd5,
    EV_LSTART = 3'd6,
    EV_LHOLD  = 3'd7
  } evt_t;

  localparam int MAX_EVENTS = 3;

  // configuration register indexes
  localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE     = 2'd1;
  localparam logic [1:0] REG_SHORT        = 2'd2;
  localparam logic [1:0] REG_LONG         = 2'd3;

  localparam logic        ACTIVE_LEVEL_RST = 1'b0;
  localparam logic [7:0]  DEBOUNCE_RST     = 8'd3;
  localparam logic [15:0] SHORT_RST        = 16'd60;
  localparam logic [15:0] LONG_RST         = 16'd200;

  typedef struct packed {
    logic        active_level;
    logic [7:0]  debounce_ticks;
    logic [15:0] short_ticks;
    logic [15:0] long_ticks;
  } cfg_t;

  // all results of one tick
  typedef struct packed {
    evt_t [MAX_EVENTS-1:0] evs;
    logic [1:0]            last_idx;
    evt_t                  status;
    logic [7:0]            count;
  } batch_t;

endpackage

>>> src/button_click_event_detector.sv
// an accepted tick is registered in the input stage, then its results in the output queue
// throughput: one tick per cycle while each tick gives one result and the output is
//   not stalled; a tick giving n results (up to 3) holds the output until all n are taken, one per result
// the output side buffers two ticks' results, the input side one tick
// reset clears the phase machine, timers and queues and loads the default
//   registers; the debounced level starts at the inverse of the active level
`include "button_click_event_detector_macros.svh"

module button_click_event_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        pin_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  fired_event,
  output logic [2:0]  status_event,
  output logic [7:0]  click_count,
  output logic        last_of_tick
);

  bced_pkg::cfg_t   cfg;
  logic             stage_valid;
  logic             stage_pin;
  logic             q_full;
  logic             step;
  bced_pkg::batch_t batch;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level   <= bced_pkg::ACTIVE_LEVEL_RST;
      cfg.debounce_ticks <= bced_pkg::DEBOUNCE_RST;
      cfg.short_ticks    <= bced_pkg::SHORT_RST;
      cfg.long_ticks     <= bced_pkg::LONG_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bced_pkg::REG_ACTIVE_LEVEL: cfg.active_level   <= cfg_data[0];
        bced_pkg::REG_DEBOUNCE:     cfg.debounce_ticks <= cfg_data[7:0];
        bced_pkg::REG_SHORT:        cfg.short_ticks    <= cfg_data;
        bced_pkg::REG_LONG:         cfg.long_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // the staged request moves into the core whenever the queue has room
  assign step     = stage_valid && !q_full;
  assign in_ready = !stage_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_pin <= pin_level;
    end
  end

  bced_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .step  (step),
    .pin   (stage_pin),
    .batch (batch)
  );

  bced_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (step),
    .push_batch   (batch),
    .full         (q_full),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .fired_event  (fired_event),
    .status_event (status_event),
    .click_count  (click_count),
    .last_of_tick (last_of_tick)
  );

  `BCED_ASSERT_RST(a_reset_empties, rst, !out_valid && in_ready, "queues not empty after reset")
  `BCED_ASSERT_NEXT(a_tick_continues, out_valid && out_ready && !last_of_tick, out_valid, "results of a tick broken up")
  `BCED_ASSERT_NEXT(a_status_steady, out_valid && out_ready && !last_of_tick, status_event == $past(status_event) && click_count == $past(click_count), "status changed within a tick")
  `BCED_ASSERT_NOW(a_none_alone, out_valid && fired_event == bced_pkg::EV_NONE, last_of_tick, "none result not last of its tick")

endmodule

>>> src/bced_core.sv
module bced_core (
  input  logic            clk,
  input  logic            rst,
  input  bced_pkg::cfg_t  cfg,
  input  logic            step,
  input  logic            pin,
  output bced_pkg::batch_t batch
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PRESS  = 3'd1,
    PH_WAIT   = 3'd2,
    PH_REPEAT = 3'd3,
    PH_LONG   = 3'd5
  } phase_t;

  phase_t           phase, phase_next;
  logic             stable_level, stable_level_next;
  logic [7:0]       debounce_count, debounce_count_next;
  logic [15:0]      tick_count, tick_count_next;
  logic [7:0]       repeat_count, repeat_count_next;
  bced_pkg::evt_t   status_code, status_code_next;

  logic             pressed;
  logic [7:0]       dc_inc;

  always_comb begin
    phase_next          = phase;
    stable_level_next   = stable_level;
    debounce_count_next = 8'd0;
    tick_count_next     = tick_count;
    repeat_count_next   = repeat_count;
    status_code_next    = status_code;
    dc_inc              = debounce_count;
    batch.evs           = '{default: bced_pkg::EV_NONE};
    batch.last_idx      = 2'd0;

    if (phase != PH_IDLE && tick_count != 16'hFFFF) begin
      tick_count_next = tick_count + 16'd1;
    end

    if (pin != stable_level) begin
      if (debounce_count != 8'hFF) begin
        dc_inc = debounce_count + 8'd1;
      end
      if (dc_inc >= cfg.debounce_ticks) begin
        stable_level_next   = pin;
        debounce_count_next = 8'd0;
      end else begin
        debounce_count_next = dc_inc;
      end
    end

    pressed = (stable_level_next == cfg.active_level);

    case (phase)
      PH_IDLE: begin
        if (pressed) begin
          status_code_next  = bced_pkg::EV_DOWN;
          batch.evs[0]      = bced_pkg::EV_DOWN;
          tick_count_next   = 16'd0;
          repeat_count_next = 8'd1;
          phase_next        = PH_PRESS;
        end else begin
          status_code_next = bced_pkg::EV_NONE;
        end
      end
      PH_PRESS: begin
        if (!pressed) begin
          status_code_next = bced_pkg::EV_UP;
          batch.evs[0]     = bced_pkg::EV_UP;
          tick_count_next  = 16'd0;
          phase_next       = PH_WAIT;
        end else if (tick_count_next > cfg.long_ticks) begin
          status_code_next = bced_pkg::EV_LSTART;
          batch.evs[0]     = bced_pkg::EV_LSTART;
          phase_next       = PH_LONG;
        end
      end
      PH_WAIT: begin
        if (pressed) begin
          status_code_next = bced_pkg::EV_DOWN;
          if (repeat_count != 8'hFF) begin
            repeat_count_next = repeat_count + 8'd1;
          end
          batch.evs[0] = bced_pkg::EV_DOWN;
          if (repeat_count_next == 8'd2) begin
            batch.evs[1]   = bced_pkg::EV_DOUBLE;
            batch.evs[2]   = bced_pkg::EV_REPEAT;
            batch.last_idx = 2'd2;
          end else begin
            batch.evs[1]   = bced_pkg::EV_REPEAT;
            batch.last_idx = 2'd1;
          end
          tick_count_next = 16'd0;
          phase_next      = PH_REPEAT;
        end else if (tick_count_next > cfg.short_ticks) begin
          if (repeat_count == 8'd1) begin
            status_code_next = bced_pkg::EV_SINGLE;
            batch.evs[0]     = bced_pkg::EV_SINGLE;
          end else if (repeat_count == 8'd2) begin
            // at the gap timeout a double click is only reported through the status
            status_code_next = bced_pkg::EV_DOUBLE;
          end
          phase_next = PH_IDLE;
        end
      end
      PH_REPEAT: begin
        if (!pressed) begin
          status_code_next = bced_pkg::EV_UP;
          batch.evs[0]     = bced_pkg::EV_UP;
          if (tick_count_next < cfg.short_ticks) begin
            tick_count_next = 16'd0;
            phase_next      = PH_WAIT;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_LONG: begin
        if (pressed) begin
          status_code_next = bced_pkg::EV_LHOLD;
          batch.evs[0]     = bced_pkg::EV_LHOLD;
        end else begin
          status_code_next = bced_pkg::EV_UP;
          batch.evs[0]     = bced_pkg::EV_UP;
          phase_next       = PH_IDLE;
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        status_code_next = bced_pkg::EV_NONE;
      end
    endcase

    batch.status = status_code_next;
    batch.count  = repeat_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      stable_level   <= ~bced_pkg::ACTIVE_LEVEL_RST;
      debounce_count <= 8'd0;
      tick_count     <= 16'd0;
      repeat_count   <= 8'd0;
      status_code    <= bced_pkg::EV_NONE;
    end else if (step) begin
      phase          <= phase_next;
      stable_level   <= stable_level_next;
      debounce_count <= debounce_count_next;
      tick_count     <= tick_count_next;
      repeat_count   <= repeat_count_next;
      status_code    <= status_code_next;
    end
  end

endmodule

>>> src/bced_outq.sv
module bced_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bced_pkg::batch_t push_batch,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       fired_event,
  output logic [2:0]       status_event,
  output logic [7:0]       click_count,
  output logic             last_of_tick
);

  bced_pkg::batch_t mem [2];
  logic             head;
  logic [1:0]       cnt;
  logic [1:0]       idx;
  logic             tail;
  logic             pop;
  bced_pkg::batch_t cur;

  assign cur          = mem[head];
  assign tail         = head ^ cnt[0];
  assign full         = cnt[1];
  assign out_valid    = (cnt != 2'd0);
  assign fired_event  = cur.evs[idx];
  assign status_event = cur.status;
  assign click_count  = cur.count;
  assign last_of_tick = (idx == cur.last_idx);
  // batch leaves once its final result is taken
  assign pop          = out_valid && out_ready && last_of_tick;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_batch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 1'b0;
      cnt  <= 2'd0;
      idx  <= 2'd0;
    end else begin
      if (pop) begin
        head <= ~head;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
      if (out_valid && out_ready) begin
        idx <= last_of_tick ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

>>> tb/tb_button_click_event_detector.sv
module tb_button_click_event_detector;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_SHOWN      = 20;

  // button phases, same codes as the block's phase machine
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_HELD   = 3'd1,
    S_GAP    = 3'd2,
    S_REHELD = 3'd3,
    S_LONG   = 3'd5
  } btn_phase_t;

  typedef struct packed {
    bced_pkg::evt_t fired;
    bced_pkg::evt_t status;
    logic [7:0]     clicks;
    logic           is_last;
  } tick_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        pin_level = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  fired_event;
  logic [2:0]  status_event;
  logic [7:0]  click_count;
  logic        last_of_tick;

  // predictor copy of the block
  bced_pkg::cfg_t cur_cfg;
  btn_phase_t     btn_phase;
  logic           db_level;
  logic [7:0]     db_count;
  logic [15:0]    hold_ticks;
  logic [7:0]     clicks;
  bced_pkg::evt_t status;
  tick_event_t    expected_events[$];

  int send_gap_pct = 0;
  int ready_stall_pct = 0;
  int n_ticks = 0;
  int n_checked = 0;
  int n_writes = 0;
  int n_errors = 0;
  int idle_cycles = 0;

  button_click_event_detector u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pin_level    (pin_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .fired_event  (fired_event),
    .status_event (status_event),
    .click_count  (click_count),
    .last_of_tick (last_of_tick)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_SHOWN) $display("mismatch: %s", msg);
  endtask

  // timer, then debounce, then the phase machine; events queued in firing order
  function automatic void predict_tick(input logic lvl);
    bced_pkg::evt_t fired_q[$];
    logic           pressed;
    tick_event_t    rec;
    if (btn_phase != S_IDLE && hold_ticks != 16'hFFFF) hold_ticks++;
    if (lvl != db_level) begin
      if (db_count != 8'hFF) db_count++;
      if (db_count >= cur_cfg.debounce_ticks) begin
        db_level = lvl;
        db_count = '0;
      end
    end else begin
      db_count = '0;
    end
    pressed = (db_level == cur_cfg.active_level);
    case (btn_phase)
      S_IDLE: begin
        if (pressed) begin
          status = bced_pkg::EV_DOWN;
          fired_q.push_back(bced_pkg::EV_DOWN);
          hold_ticks = '0;
          clicks = 8'd1;
          btn_phase = S_HELD;
        end else begin
          status = bced_pkg::EV_NONE;
        end
      end
      S_HELD: begin
        if (!pressed) begin
          status = bced_pkg::EV_UP;
          fired_q.push_back(bced_pkg::EV_UP);
          hold_ticks = '0;
          btn_phase = S_GAP;
        end else if (hold_ticks > cur_cfg.long_ticks) begin
          status = bced_pkg::EV_LSTART;
          fired_q.push_back(bced_pkg::EV_LSTART);
          btn_phase = S_LONG;
        end
      end
      S_GAP: begin
        if (pressed) begin
          status = bced_pkg::EV_DOWN;
          fired_q.push_back(bced_pkg::EV_DOWN);
          if (clicks != 8'hFF) clicks++;
          if (clicks == 8'd2) fired_q.push_back(bced_pkg::EV_DOUBLE);
          fired_q.push_back(bced_pkg::EV_REPEAT);
          hold_ticks = '0;
          btn_phase = S_REHELD;
        end else if (hold_ticks > cur_cfg.short_ticks) begin
          // two clicks only update the status, three or more leave it alone
          if (clicks == 8'd1) begin
            status = bced_pkg::EV_SINGLE;
            fired_q.push_back(bced_pkg::EV_SINGLE);
          end else if (clicks == 8'd2) begin
            status = bced_pkg::EV_DOUBLE;
          end
          btn_phase = S_IDLE;
        end
      end
      S_REHELD: begin
        if (!pressed) begin
          status = bced_pkg::EV_UP;
          fired_q.push_back(bced_pkg::EV_UP);
          if (hold_ticks < cur_cfg.short_ticks) begin
            hold_ticks = '0;
            btn_phase = S_GAP;
          end else begin
            btn_phase = S_IDLE;
          end
        end
      end
      S_LONG: begin
        if (pressed) begin
          status = bced_pkg::EV_LHOLD;
          fired_q.push_back(bced_pkg::EV_LHOLD);
        end else begin
          status = bced_pkg::EV_UP;
          fired_q.push_back(bced_pkg::EV_UP);
          btn_phase = S_IDLE;
        end
      end
      default: begin
        btn_phase = S_IDLE;
        status = bced_pkg::EV_NONE;
      end
    endcase
    if (fired_q.size() == 0) fired_q.push_back(bced_pkg::EV_NONE);
    foreach (fired_q[k]) begin
      rec.fired   = fired_q[k];
      rec.status  = status;
      rec.clicks  = clicks;
      rec.is_last = (k == fired_q.size() - 1);
      expected_events.push_back(rec);
    end
  endfunction

  always @(posedge clk) begin
    tick_event_t want;
    if (rst) begin
      cur_cfg    = '{bced_pkg::ACTIVE_LEVEL_RST, bced_pkg::DEBOUNCE_RST,
                     bced_pkg::SHORT_RST, bced_pkg::LONG_RST};
      btn_phase  = S_IDLE;
      db_level   = ~bced_pkg::ACTIVE_LEVEL_RST;
      db_count   = '0;
      hold_ticks = '0;
      clicks     = '0;
      status     = bced_pkg::EV_NONE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bced_pkg::REG_ACTIVE_LEVEL: cur_cfg.active_level   = cfg_data[0];
          bced_pkg::REG_DEBOUNCE:     cur_cfg.debounce_ticks = cfg_data[7:0];
          bced_pkg::REG_SHORT:        cur_cfg.short_ticks    = cfg_data;
          bced_pkg::REG_LONG:         cur_cfg.long_ticks     = cfg_data;
          default: ;
        endcase
      end
      // check before predicting so a result cannot pair with a tick accepted in the same cycle
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("event %0d with nothing pending", fired_event));
        end else begin
          want = expected_events.pop_front();
          n_checked++;
          if (fired_event !== want.fired)
            report_mismatch($sformatf("event %0d: fired %0d, want %0d",
                                      n_checked, fired_event, want.fired));
          if (status_event !== want.status)
            report_mismatch($sformatf("event %0d: status %0d, want %0d",
                                      n_checked, status_event, want.status));
          if (click_count !== want.clicks)
            report_mismatch($sformatf("event %0d: clicks %0d, want %0d",
                                      n_checked, click_count, want.clicks));
          if (last_of_tick !== want.is_last)
            report_mismatch($sformatf("event %0d: last %0b, want %0b",
                                      n_checked, last_of_tick, want.is_last));
        end
      end
      if (in_valid && in_ready) predict_tick(pin_level);
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("[button_click_event_detector] ERROR");
      $finish;
    end
  end

  // valid stays high on return; the next call or wait_drain drops or reuses it
  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    pin_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_ticks++;
  endtask

  task automatic send_run(input logic lvl, input int n, input int flip_pct);
    repeat (n) send_tick(($urandom_range(99) < flip_pct) ? ~lvl : lvl);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_writes++;
  endtask

  task automatic set_config(input logic al, input logic [7:0] db,
                            input logic [15:0] sh, input logic [15:0] lg);
    wait_drain();
    put_reg(bced_pkg::REG_ACTIVE_LEVEL, {15'd0, al});
    put_reg(bced_pkg::REG_DEBOUNCE, {8'd0, db});
    put_reg(bced_pkg::REG_SHORT, sh);
    put_reg(bced_pkg::REG_LONG, lg);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_run(1'b0, 3, 0);
    send_run(1'b1, 3, 0);
  endtask

  task automatic test_click_patterns();
    // flipping the active level makes the released level read as pressed
    set_config(1'b1, 8'd1, 16'd2, 16'd2);
    // three clicks then gap timeout
    send_run(1'b1, 1, 0);
    send_run(1'b0, 1, 0);
    send_run(1'b1, 1, 0);
    send_run(1'b0, 4, 0);
    // double click then gap timeout
    send_run(1'b1, 1, 0);
    send_run(1'b0, 1, 0);
    send_run(1'b1, 1, 0);
    send_run(1'b0, 4, 0);
    // single click
    send_run(1'b1, 1, 0);
    send_run(1'b0, 4, 0);
    // long press with hold
    send_run(1'b1, 5, 0);
    send_run(1'b0, 1, 0);
    // second press released too late to chain
    send_run(1'b1, 1, 0);
    send_run(1'b0, 1, 0);
    send_run(1'b1, 3, 0);
    send_run(1'b0, 1, 0);
  endtask

  task automatic test_config_extremes();
    // slowest debounce never lets a short run through
    set_config(1'b0, 8'd255, 16'd1, 16'd1);
    send_run(1'b1, 6, 0);
    send_run(1'b0, 6, 0);
    set_config(1'b0, 8'd1, 16'd1, 16'd1);
    send_run(1'b0, 2, 0);
    send_run(1'b1, 1, 0);
    send_run(1'b0, 1, 0);
    send_run(1'b1, 4, 0);
    // widest gap and hold limits
    set_config(1'b1, 8'd1, 16'hFFFF, 16'hFFFF);
    send_run(1'b1, 4, 0);
    send_run(1'b0, 2, 0);
  endtask

  task automatic test_click_chain();
    set_config(1'b0, 8'd1, 16'd10, 16'd100);
    repeat (6) begin
      send_run(1'b1, 1, 0);
      send_run(1'b0, 1, 0);
    end
    send_run(1'b1, 12, 0);
  endtask

  // mostly press/release runs with glitches, some raw noise
  task automatic test_random_clicks(input int n);
    int   start;
    int   db;
    int   sh;
    int   lg;
    logic act;
    logic lvl;
    start = n_ticks;
    while (n_ticks - start < n) begin
      act = 1'($urandom_range(1));
      db  = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
      sh  = $urandom_range(2, 10);
      lg  = $urandom_range(3, 16);
      set_config(act, 8'(db), 16'(sh), 16'(lg));
      repeat (3) begin
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 6)) begin
            lvl = 1'($urandom_range(1));
            send_tick(lvl);
          end
        end else begin
          send_run(act, db + $urandom_range(0, lg + 4), 8);
          send_run(~act, db + $urandom_range(0, sh + 4), 8);
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct = 33;
    ready_stall_pct = 49;
    test_reset_defaults();
    test_click_patterns();
    test_random_clicks(40);

    send_gap_pct = 49;
    ready_stall_pct = 33;
    test_config_extremes();
    test_random_clicks(40);

    send_gap_pct = 0;
    ready_stall_pct = 0;
    test_click_chain();
    test_random_clicks(40);

    wait_drain();
    repeat (10) @(posedge clk);
    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d events never arrived", expected_events.size()));

    $display("covered %0d ticks: default setup, click patterns, register extremes,",
             n_ticks);
    $display("  long click chains and random presses; %0d events, %0d register writes",
             n_checked, n_writes);
    if (n_errors == 0)
      $display("[button_click_event_detector] OK");
    else
      $display("[button_click_event_detector] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/bced_pkg.sv
src/bced_core.sv
src/bced_outq.sv
src/button_click_event_detector.sv
tb/tb_button_click_event_detector.sv
